@@ rtl/dmwbc_pkg.sv @@
// Shared constants and types of the direct-mapped write-back cache.
package dmwbc_pkg;

    localparam int MODE_W  = 2;
    localparam int COUNT_W = 3;
    localparam int DATA_W  = 32;

    localparam logic [MODE_W-1:0] MODE_READ    = 2'd0;
    localparam logic [MODE_W-1:0] MODE_WRITE   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_PRELOAD = 2'd2;
    localparam logic [MODE_W-1:0] MODE_UNUSED  = 2'd3;

    localparam logic [COUNT_W-1:0] MAX_COUNT = 3'd4;

    typedef struct packed {
        logic               wr_en;
        logic [COUNT_W-1:0] count;
    } t_merge_ctl;

endpackage

@@ rtl/dmwbc_if.sv @@
// Request and response channel interfaces of the direct-mapped write-back cache.
interface dmwbc_req_if #(
    parameter int ADDR_BITS = 16
);
    logic                             valid;
    logic                             ready;
    logic [dmwbc_pkg::MODE_W-1:0]     mode;
    logic [ADDR_BITS-1:0]             addr;
    logic [dmwbc_pkg::COUNT_W-1:0]    write_count;
    logic [dmwbc_pkg::DATA_W-1:0]     write_data;

    modport source (output valid, mode, addr, write_count, write_data, input ready);
    modport sink   (input valid, mode, addr, write_count, write_data, output ready);
endinterface

interface dmwbc_rsp_if #(
    parameter int LINE_W = 3,
    parameter int TAG_W  = 9,
    parameter int OFF_W  = 4
);
    logic                          valid;
    logic                          ready;
    logic [LINE_W-1:0]             line_index;
    logic [TAG_W-1:0]              tag_value;
    logic [OFF_W-1:0]              byte_offset;
    logic                          hit;
    logic                          wrote_back;
    logic [dmwbc_pkg::DATA_W-1:0]  read_data;

    modport source (output valid, line_index, tag_value, byte_offset, hit, wrote_back,
                    read_data, input ready);
    modport sink   (input valid, line_index, tag_value, byte_offset, hit, wrote_back,
                    read_data, output ready);
endinterface

@@ rtl/direct_mapped_writeback_cache_core.sv @@
// Top level of the direct-mapped write-back write-allocate byte cache.
// A response is registered when its request executes, which waits while a response is held.
// A request is taken only in idle, after the registered memory read and merge of the last.
// Reset: all lines invalid; a clearing pass zeroes the backing memory, one block a cycle,
// all 2**ADDR_BITS/BLOCK_BYTES blocks (4096 by default), with ready held low.
module direct_mapped_writeback_cache_core #(
    parameter int NUM_LINES   = 8,
    parameter int BLOCK_BYTES = 16,
    parameter int ADDR_BITS   = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    dmwbc_req_if.sink          i_req,
    dmwbc_rsp_if.source        o_rsp
);

    localparam int OB        = $clog2(BLOCK_BYTES);
    localparam int LB        = $clog2(NUM_LINES);
    localparam int TAG_W     = ADDR_BITS - OB - LB;
    localparam int BLK_W     = BLOCK_BYTES * 8;
    localparam int MEM_AW    = ADDR_BITS - OB;
    localparam int MEM_DEPTH = 2 ** MEM_AW;
    localparam int LINE_W    = TAG_W + BLK_W;

    localparam logic [1:0] S_CLEAR = 2'd0;
    localparam logic [1:0] S_IDLE  = 2'd1;
    localparam logic [1:0] S_EXEC  = 2'd2;

    logic [1:0]                      r_state, n_state;
    logic [MEM_AW-1:0]               r_clr_addr;
    logic [NUM_LINES-1:0]            r_valid;
    logic [NUM_LINES-1:0]            r_dirty;
    logic [dmwbc_pkg::MODE_W-1:0]    r_mode;
    logic [ADDR_BITS-1:0]            r_addr;
    logic [dmwbc_pkg::COUNT_W-1:0]   r_count;
    logic [dmwbc_pkg::DATA_W-1:0]    r_wdata;

    logic                            r_out_valid;
    logic [LB-1:0]                   r_out_line;
    logic [TAG_W-1:0]                r_out_tag;
    logic [OB-1:0]                   r_out_off;
    logic                            r_out_hit;
    logic                            r_out_wb;
    logic [dmwbc_pkg::DATA_W-1:0]    r_out_rdata;

    logic                            accept;
    logic                            fire;
    logic                            cached;
    logic [LB-1:0]                   cur_line;
    logic [TAG_W-1:0]                cur_tag;
    logic [OB-1:0]                   cur_off;
    logic [MEM_AW-1:0]               cur_blk;
    logic [LINE_W-1:0]               line_rdata;
    logic [BLK_W-1:0]                mem_rdata;
    logic [TAG_W-1:0]                old_tag;
    logic [BLK_W-1:0]                old_data;
    logic                            line_hit;
    logic                            victim;
    logic [BLK_W-1:0]                merge_in;
    logic [BLK_W-1:0]                merged;
    logic [dmwbc_pkg::DATA_W-1:0]    gathered;
    dmwbc_pkg::t_merge_ctl           merge_ctl;

    logic                            mem_we;
    logic [MEM_AW-1:0]               mem_waddr;
    logic [BLK_W-1:0]                mem_wdata;
    logic                            line_we;

    assign accept = i_req.valid && i_req.ready;
    assign fire   = (r_state == S_EXEC) && (!r_out_valid || o_rsp.ready);
    assign cached = (r_mode == dmwbc_pkg::MODE_READ) || (r_mode == dmwbc_pkg::MODE_WRITE);

    assign cur_off  = r_addr[OB-1:0];
    assign cur_line = r_addr[OB +: LB];
    assign cur_tag  = r_addr[OB+LB +: TAG_W];
    assign cur_blk  = r_addr[ADDR_BITS-1:OB];

    assign old_tag  = line_rdata[BLK_W +: TAG_W];
    assign old_data = line_rdata[BLK_W-1:0];
    assign line_hit = r_valid[cur_line] && (old_tag == cur_tag);
    assign victim   = !line_hit && r_valid[cur_line] && r_dirty[cur_line];

    assign merge_in        = ((r_mode == dmwbc_pkg::MODE_PRELOAD) || !line_hit) ? mem_rdata
                                                                                : old_data;
    assign merge_ctl.wr_en = (r_mode == dmwbc_pkg::MODE_WRITE)
                          || (r_mode == dmwbc_pkg::MODE_PRELOAD);
    assign merge_ctl.count = r_count;

    dmwbc_merge #(
        .BLOCK_BYTES (BLOCK_BYTES)
    ) u_merge (
        .i_block  (merge_in),
        .i_offset (cur_off),
        .i_ctl    (merge_ctl),
        .i_wdata  (r_wdata),
        .o_block  (merged),
        .o_gather (gathered)
    );

    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = cur_blk;
        mem_wdata = merged;
        case (r_state)
            S_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = r_clr_addr;
                mem_wdata = '0;
            end
            S_EXEC: begin
                if (fire && (r_mode == dmwbc_pkg::MODE_PRELOAD)) begin
                    mem_we = 1'b1;
                end else if (fire && cached && victim) begin
                    mem_we    = 1'b1;
                    mem_waddr = {old_tag, cur_line};
                    mem_wdata = old_data;
                end
            end
            default: begin
                mem_we = 1'b0;
            end
        endcase
    end

    assign line_we = fire && cached;

    dmwbc_ram #(
        .WIDTH (BLK_W),
        .DEPTH (MEM_DEPTH)
    ) u_backing_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (accept),
        .i_raddr (i_req.addr[ADDR_BITS-1:OB]),
        .o_rdata (mem_rdata)
    );

    dmwbc_ram #(
        .WIDTH (LINE_W),
        .DEPTH (NUM_LINES)
    ) u_line_mem (
        .i_clk   (i_clk),
        .i_we    (line_we),
        .i_waddr (cur_line),
        .i_wdata ({cur_tag, merged}),
        .i_re    (accept),
        .i_raddr (i_req.addr[OB +: LB]),
        .o_rdata (line_rdata)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (r_clr_addr == MEM_AW'(MEM_DEPTH - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (fire) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_addr  <= '0;
            r_valid     <= '0;
            r_dirty     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
            if (line_we) begin
                r_valid[cur_line] <= 1'b1;
                r_dirty[cur_line] <= (r_mode == dmwbc_pkg::MODE_WRITE)
                                  || (line_hit && r_dirty[cur_line]);
            end
            if (fire) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_mode  <= i_req.mode;
            r_addr  <= i_req.addr;
            r_count <= i_req.write_count;
            r_wdata <= i_req.write_data;
        end
        if (fire) begin
            r_out_line  <= cur_line;
            r_out_tag   <= cur_tag;
            r_out_off   <= cur_off;
            r_out_hit   <= cached && line_hit;
            r_out_wb    <= cached && victim;
            r_out_rdata <= (r_mode == dmwbc_pkg::MODE_UNUSED) ? '0 : gathered;
        end
    end

    assign i_req.ready       = (r_state == S_IDLE);
    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.line_index  = r_out_line;
    assign o_rsp.tag_value   = r_out_tag;
    assign o_rsp.byte_offset = r_out_off;
    assign o_rsp.hit         = r_out_hit;
    assign o_rsp.wrote_back  = r_out_wb;
    assign o_rsp.read_data   = r_out_rdata;

    a_accept_to_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state == S_EXEC))
        else $error("accepted request did not enter execution");

    a_rsp_from_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_rsp.valid) |-> $past(r_state == S_EXEC))
        else $error("response appeared without an executed request");

    a_mem_write_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_EXEC) && mem_we)
            |-> ((r_mode == dmwbc_pkg::MODE_PRELOAD) || (cached && victim)))
        else $error("backing memory written without preload or dirty victim");

    a_wb_not_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.wrote_back) |-> !o_rsp.hit)
        else $error("write-back reported on a hit");

endmodule

@@ rtl/dmwbc_ram.sv @@
// Generic single-clock RAM with one write port and one registered read port.
module dmwbc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/dmwbc_merge.sv @@
// Byte merge of write data into a block and four-byte gather from the offset.
module dmwbc_merge #(
    parameter int BLOCK_BYTES = 16
) (
    input  logic [BLOCK_BYTES*8-1:0]         i_block,
    input  logic [$clog2(BLOCK_BYTES)-1:0]   i_offset,
    input  dmwbc_pkg::t_merge_ctl            i_ctl,
    input  logic [dmwbc_pkg::DATA_W-1:0]     i_wdata,
    output logic [BLOCK_BYTES*8-1:0]         o_block,
    output logic [dmwbc_pkg::DATA_W-1:0]     o_gather
);

    localparam int OB = $clog2(BLOCK_BYTES);

    logic [dmwbc_pkg::COUNT_W-1:0] count_sat;
    logic [OB:0]                   rel [BLOCK_BYTES];
    logic [OB:0]                   pos [4];

    always_comb begin
        count_sat = (i_ctl.count > dmwbc_pkg::MAX_COUNT) ? dmwbc_pkg::MAX_COUNT : i_ctl.count;
        for (int j = 0; j < BLOCK_BYTES; j++) begin
            rel[j] = {1'b0, OB'(j)} - {1'b0, i_offset};
            o_block[j*8 +: 8] = i_block[j*8 +: 8];
            if (i_ctl.wr_en && (OB'(j) >= i_offset) && (rel[j] < (OB+1)'(count_sat))) begin
                o_block[j*8 +: 8] = i_wdata[{rel[j][1:0], 3'b000} +: 8];
            end
        end
    end

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            pos[i] = {1'b0, i_offset} + (OB+1)'(i);
            o_gather[i*8 +: 8] = 8'd0;
            if (!pos[i][OB]) begin
                o_gather[i*8 +: 8] = o_block[{pos[i][OB-1:0], 3'b000} +: 8];
            end
        end
    end

endmodule

@@ test/cache_checker.sv @@
// Scoreboard that predicts every response of the write-back cache and checks it.
module cache_checker
    import dmwbc_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    dmwbc_req_if i_req,
    dmwbc_rsp_if i_rsp,
    output int   o_fail_count,
    output int   o_pending
);

    localparam int NUM_LINES   = 8;
    localparam int BLOCK_BYTES = 16;
    localparam int MEM_BLOCKS  = 4096;

    typedef struct packed {
        logic [2:0]        line_index;
        logic [8:0]        tag_value;
        logic [3:0]        byte_offset;
        logic              hit;
        logic              wrote_back;
        logic [DATA_W-1:0] read_data;
    } t_access_result;

    logic         line_valid [NUM_LINES];
    logic         line_dirty [NUM_LINES];
    logic [8:0]   line_tag   [NUM_LINES];
    logic [127:0] line_data  [NUM_LINES];
    logic [127:0] backing_mem [MEM_BLOCKS];

    t_access_result expected_rsp_q [$];
    int             mismatch_cnt;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        mismatch_cnt = 0;
    end

    function automatic logic [DATA_W-1:0] pick_word(logic [127:0] blk, int off);
        logic [DATA_W-1:0] word;
        word = '0;
        for (int i = 0; i < 4; i++) begin
            if (off + i < BLOCK_BYTES) begin
                word[8*i +: 8] = blk[8*(off+i) +: 8];
            end
        end
        return word;
    endfunction

    function automatic t_access_result model_access(logic [MODE_W-1:0] mode, logic [15:0] addr,
                                                    logic [COUNT_W-1:0] count,
                                                    logic [DATA_W-1:0] wdata);
        t_access_result res;
        int             off;
        int             nbytes;
        logic [2:0]     line;
        logic [8:0]     tag;
        logic [11:0]    blk;
        res    = '0;
        off    = int'(addr[3:0]);
        line   = addr[6:4];
        tag    = addr[15:7];
        blk    = addr[15:4];
        nbytes = (count > MAX_COUNT) ? int'(MAX_COUNT) : int'(count);
        if (off + nbytes > BLOCK_BYTES) begin
            nbytes = BLOCK_BYTES - off;
        end
        res.line_index  = line;
        res.tag_value   = tag;
        res.byte_offset = addr[3:0];
        case (mode)
            MODE_PRELOAD: begin
                for (int i = 0; i < nbytes; i++) begin
                    backing_mem[blk][8*(off+i) +: 8] = wdata[8*i +: 8];
                end
                res.read_data = pick_word(backing_mem[blk], off);
            end
            MODE_READ, MODE_WRITE: begin
                if (line_valid[line] && line_tag[line] == tag) begin
                    res.hit = 1'b1;
                end else begin
                    if (line_valid[line] && line_dirty[line]) begin
                        backing_mem[{line_tag[line], line}] = line_data[line];
                        res.wrote_back = 1'b1;
                    end
                    line_data[line]  = backing_mem[blk];
                    line_valid[line] = 1'b1;
                    line_dirty[line] = 1'b0;
                    line_tag[line]   = tag;
                end
                if (mode == MODE_WRITE) begin
                    for (int i = 0; i < nbytes; i++) begin
                        line_data[line][8*(off+i) +: 8] = wdata[8*i +: 8];
                    end
                    line_dirty[line] = 1'b1;
                end
                res.read_data = pick_word(line_data[line], off);
            end
            default: ;
        endcase
        return res;
    endfunction

    function automatic int field_differs(string field, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch: expected 0x%0h, actual 0x%0h", $time, field, want, got);
            return 1;
        end
        return 0;
    endfunction

    always @(posedge i_clk) begin
        t_access_result want;
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_LINES; k++) begin
                line_valid[k] = 1'b0;
                line_dirty[k] = 1'b0;
                line_tag[k]   = '0;
                line_data[k]  = '0;
            end
            for (int k = 0; k < MEM_BLOCKS; k++) begin
                backing_mem[k] = '0;
            end
            expected_rsp_q.delete();
        end else begin
            if (i_rsp.valid && i_rsp.ready) begin
                if (expected_rsp_q.size() == 0) begin
                    $display("%0t: response with none expected: expected none, actual 0x%0h",
                             $time, i_rsp.read_data);
                    mismatch_cnt++;
                end else begin
                    want = expected_rsp_q.pop_front();
                    mismatch_cnt += field_differs("line_index", want.line_index,
                                                  i_rsp.line_index)
                                  + field_differs("tag_value", want.tag_value, i_rsp.tag_value)
                                  + field_differs("byte_offset", want.byte_offset,
                                                  i_rsp.byte_offset)
                                  + field_differs("hit", want.hit, i_rsp.hit)
                                  + field_differs("wrote_back", want.wrote_back,
                                                  i_rsp.wrote_back)
                                  + field_differs("read_data", want.read_data,
                                                  i_rsp.read_data);
                end
            end
            if (i_req.valid && i_req.ready) begin
                expected_rsp_q.insert(expected_rsp_q.size(),
                                      model_access(i_req.mode, i_req.addr,
                                                   i_req.write_count, i_req.write_data));
            end
        end
        o_pending    <= expected_rsp_q.size();
        o_fail_count <= mismatch_cnt;
    end

endmodule

@@ test/testbench.sv @@
// Top of the cache testbench: clock, reset, request stimulus, response stalls and verdict.
module testbench;
    import dmwbc_pkg::*;

    localparam int IDLE_LIMIT = 20000;

    logic       i_clk;
    logic       i_rst_n;
    int         fail_count;
    int         pending_count;
    int         idle_cycles;
    int         send_idle_pct;
    int         recv_stall_pct;
    logic [8:0] hot_tags [4];

    dmwbc_req_if #(.ADDR_BITS(16)) req_ch ();
    dmwbc_rsp_if                   rsp_ch ();

    direct_mapped_writeback_cache_core uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    cache_checker u_cache_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req        (req_ch),
        .i_rsp        (rsp_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        rsp_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    initial begin
        idle_cycles = 0;
        forever begin
            @(posedge i_clk);
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    task automatic send_request(logic [MODE_W-1:0] mode, logic [15:0] addr,
                                logic [COUNT_W-1:0] count, logic [DATA_W-1:0] wdata);
        while ($urandom_range(99) < send_idle_pct) begin
            req_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_ch.mode        <= mode;
        req_ch.addr        <= addr;
        req_ch.write_count <= count;
        req_ch.write_data  <= wdata;
        req_ch.valid       <= 1'b1;
        do @(posedge i_clk); while (!req_ch.ready);
    endtask

    task automatic send_random_request();
        logic [MODE_W-1:0]  mode;
        logic [15:0]        addr;
        logic [COUNT_W-1:0] count;
        int                 pick;
        pick = $urandom_range(99);
        if (pick < 40) begin
            mode = MODE_READ;
        end else if (pick < 80) begin
            mode = MODE_WRITE;
        end else if (pick < 95) begin
            mode = MODE_PRELOAD;
        end else begin
            mode = MODE_UNUSED;
        end
        if ($urandom_range(99) < 75) begin
            addr = {hot_tags[$urandom_range(3)], 7'($urandom)};
        end else begin
            addr = 16'($urandom);
        end
        if ($urandom_range(99) < 80) begin
            count = COUNT_W'($urandom_range(4, 1));
        end else begin
            count = COUNT_W'($urandom_range(7));
        end
        send_request(mode, addr, count, $urandom);
    endtask

    task automatic drain_responses();
        req_ch.valid <= 1'b0;
        do @(posedge i_clk); while (pending_count != 0);
    endtask

    initial begin
        i_rst_n            <= 1'b0;
        req_ch.valid       <= 1'b0;
        req_ch.mode        <= MODE_READ;
        req_ch.addr        <= '0;
        req_ch.write_count <= '0;
        req_ch.write_data  <= '0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        foreach (hot_tags[k]) begin
            hot_tags[k] = 9'($urandom);
        end
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_request(MODE_READ,    16'h0000, 3'd0, 32'h0000_0000);
        send_request(MODE_WRITE,   16'h0000, 3'd4, 32'hDEAD_BEEF);
        send_request(MODE_WRITE,   16'h000E, 3'd4, 32'h1122_3344);
        send_request(MODE_WRITE,   16'h0005, 3'd7, 32'hA5A5_A5A5);
        send_request(MODE_READ,    16'h000C, 3'd0, 32'h0000_0000);
        send_request(MODE_READ,    16'h0080, 3'd0, 32'h0000_0000);
        send_request(MODE_READ,    16'h0000, 3'd0, 32'h0000_0000);
        send_request(MODE_WRITE,   16'h0010, 3'd0, 32'hFFFF_FFFF);
        send_request(MODE_READ,    16'hFF90, 3'd0, 32'h0000_0000);
        send_request(MODE_PRELOAD, 16'h1234, 3'd4, 32'hCAFE_F00D);
        send_request(MODE_READ,    16'h1230, 3'd0, 32'h0000_0000);
        send_request(MODE_PRELOAD, 16'h1230, 3'd2, 32'h0000_BEEF);
        send_request(MODE_READ,    16'h1230, 3'd0, 32'h0000_0000);
        send_request(MODE_PRELOAD, 16'hFFFF, 3'd4, 32'hFFFF_FFFF);
        send_request(MODE_PRELOAD, 16'hFFF0, 3'd0, 32'h0000_0000);
        send_request(MODE_READ,    16'hFFFF, 3'd0, 32'h0000_0000);
        send_request(MODE_WRITE,   16'hFFFC, 3'd4, 32'hFFFF_FFFF);
        send_request(MODE_UNUSED,  16'hABCD, 3'd4, 32'h1234_5678);
        send_request(MODE_READ,    16'hABCD, 3'd7, 32'hFFFF_FFFF);
        send_request(MODE_WRITE,   16'h7F7F, 3'd3, 32'h00FF_00FF);
        send_request(MODE_READ,    16'h0070, 3'd0, 32'h0000_0000);
        drain_responses();

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1: begin
                    send_idle_pct  = 68;
                    recv_stall_pct = 0;
                end
                2: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 68;
                end
                default: begin
                    send_idle_pct  = 9;
                    recv_stall_pct = 9;
                end
            endcase
            repeat (288) send_random_request();
            drain_responses();
        end

        repeat (10) @(posedge i_clk);
        if (fail_count == 0 && pending_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

@@ direct_mapped_writeback_cache_core.f @@
rtl/dmwbc_pkg.sv
rtl/dmwbc_if.sv
rtl/dmwbc_ram.sv
rtl/dmwbc_merge.sv
rtl/direct_mapped_writeback_cache_core.sv
test/cache_checker.sv
test/testbench.sv
